[rtl/sbie_pkg.sv]
// Shared types, codes and constants of the 16-bit instruction executor.
`timescale 1ns / 1ps
package sbie_pkg;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_STEP = 1'b1;

    localparam logic [1:0] STORE_NONE = 2'd0;
    localparam logic [1:0] STORE_BYTE = 2'd1;
    localparam logic [1:0] STORE_HALF = 2'd2;

    localparam logic [15:0] KEY_ADDR = 16'hB000;
    localparam logic [3:0]  PC_INDEX = 4'd15;

    typedef struct packed {
        logic        func;
        logic [15:0] load_addr;
        logic [7:0]  load_data;
        logic [7:0]  key_code;
    } sbie_item_t;

    typedef struct packed {
        logic [15:0] pc_value;
        logic [3:0]  flag_bits;
        logic        halted;
        logic        illegal;
        logic        reg_write;
        logic [3:0]  reg_index;
        logic [31:0] reg_value;
        logic [1:0]  store_valid;
        logic [15:0] store_addr;
        logic [15:0] store_data;
        logic        key_taken;
    } sbie_result_t;

    typedef struct packed {
        logic       valid;
        sbie_item_t item;
    } sbie_queue_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECODE,
        ST_EXECUTE,
        ST_LOAD
    } sbie_state_t;

endpackage

[rtl/sbie_if.sv]
// Valid/ready channel interfaces for input and result words.
`timescale 1ns / 1ps
interface sbie_in_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [15:0] load_addr;
    logic [7:0]  load_data;
    logic [7:0]  key_code;

    modport source (output valid, output func, output load_addr, output load_data,
                    output key_code, input ready);
    modport sink (input valid, input func, input load_addr, input load_data,
                  input key_code, output ready);
endinterface

interface sbie_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] pc_value;
    logic [3:0]  flag_bits;
    logic        halted;
    logic        illegal;
    logic        reg_write;
    logic [3:0]  reg_index;
    logic [31:0] reg_value;
    logic [1:0]  store_valid;
    logic [15:0] store_addr;
    logic [15:0] store_data;
    logic        key_taken;

    modport source (output valid, output pc_value, output flag_bits, output halted,
                    output illegal, output reg_write, output reg_index, output reg_value,
                    output store_valid, output store_addr, output store_data,
                    output key_taken, input ready);
    modport sink (input valid, input pc_value, input flag_bits, input halted,
                  input illegal, input reg_write, input reg_index, input reg_value,
                  input store_valid, input store_addr, input store_data,
                  input key_taken, output ready);
endinterface

[rtl/sixteen_bit_isa_executor_core.sv]
// Top level of the 16-bit instruction executor.
// A step passes through fetch, operand read and execute, and a memory read after execute
// when it loads from memory; a program-load word is written and answered from idle.
// Steps do not overlap: the next is taken only after the last has finished, set by the
// registered bank and register-file reads; one load word per cycle while output is free.
// Reset clears PC, flags, register valid bits and the stopped flag; memory keeps its content.
`timescale 1ns / 1ps
module sixteen_bit_isa_executor_core #(
    parameter int MEM_ADDR_BITS = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    sbie_in_if.sink    in_ch,
    sbie_out_if.source out_ch
);
    sbie_pkg::sbie_queue_t  head;
    sbie_pkg::sbie_result_t word;
    logic                   pop;

    sbie_front u_front (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .pop(pop), .head(head)
    );

    sbie_back #(.MEM_ADDR_BITS(MEM_ADDR_BITS)) u_back (
        .clk(clk), .rst_n(rst_n), .head(head), .pop(pop),
        .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_word(word)
    );

    assign out_ch.pc_value    = word.pc_value;
    assign out_ch.flag_bits   = word.flag_bits;
    assign out_ch.halted      = word.halted;
    assign out_ch.illegal     = word.illegal;
    assign out_ch.reg_write   = word.reg_write;
    assign out_ch.reg_index   = word.reg_index;
    assign out_ch.reg_value   = word.reg_value;
    assign out_ch.store_valid = word.store_valid;
    assign out_ch.store_addr  = word.store_addr;
    assign out_ch.store_data  = word.store_data;
    assign out_ch.key_taken   = word.key_taken;
endmodule

[rtl/sbie_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module sbie_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
endmodule

[rtl/sbie_front.sv]
// Front end: accepts input words into a two-entry queue.
`timescale 1ns / 1ps
module sbie_front (
    input  logic                 clk,
    input  logic                 rst_n,
    sbie_in_if.sink              in_ch,
    input  logic                 pop,
    output sbie_pkg::sbie_queue_t head
);
    sbie_pkg::sbie_item_t slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;
    logic       do_pop;

    assign in_ch.ready = (count_reg != 2'd2);
    assign push        = in_ch.valid && in_ch.ready;
    assign do_pop      = pop && (count_reg != 2'd0);

    always_comb
    begin
        wr_ptr_next = push   ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= '{func: in_ch.func, load_addr: in_ch.load_addr,
                                      load_data: in_ch.load_data, key_code: in_ch.key_code};
        end
    end

    assign head.valid = (count_reg != 2'd0);
    assign head.item  = slot_reg[rd_ptr_reg];
endmodule

[rtl/sbie_back.sv]
// Back end: writes program-load bytes, and fetches, decodes and executes one instruction at a time.
`timescale 1ns / 1ps
module sbie_back #(
    parameter int MEM_ADDR_BITS = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  sbie_pkg::sbie_queue_t  head,
    output logic                   pop,
    output logic                   out_valid,
    input  logic                   out_ready,
    output sbie_pkg::sbie_result_t out_word
);
    localparam int BANK_BITS  = MEM_ADDR_BITS - 1;
    localparam int BANK_DEPTH = 1 << BANK_BITS;

    sbie_pkg::sbie_state_t state_reg, state_next;

    logic [15:0] pc_reg, pc_next;
    logic [3:0]  flags_reg, flags_next;
    logic        stopped_reg, stopped_next;
    logic [15:0] valid_reg, valid_next;
    logic        out_valid_reg, out_valid_next;
    sbie_pkg::sbie_result_t out_word_reg, out_word_next;
    logic [15:0] ins_reg, ins_next;
    logic [7:0]  key_reg, key_next;
    logic        addr0_reg, addr0_next;
    logic [3:0]  a_idx_reg, a_idx_next;
    logic [3:0]  b_idx_reg, b_idx_next;

    logic                 bank_rd_en;
    logic [15:0]          bank_rd_addr;
    logic [BANK_BITS-1:0] even_rd_idx, odd_rd_idx;
    logic [7:0]           even_q, odd_q;
    logic [7:0]           byte_lo, byte_hi;
    logic [1:0]           mem_wr_kind;
    logic [15:0]          mem_wr_addr;
    logic [15:0]          mem_wr_data;
    logic                 even_we, odd_we;
    logic [BANK_BITS-1:0] even_wr_idx, odd_wr_idx;
    logic [7:0]           even_wd, odd_wd;

    logic        rf_rd_en;
    logic        rf_we;
    logic [3:0]  rf_wr_idx;
    logic [31:0] rf_wr_data;
    logic [31:0] rfa_q, rfb_q;
    logic [31:0] opa, opb;

    logic        out_free;
    logic        commit;
    sbie_pkg::sbie_result_t res;
    logic        ld_mem;
    logic        ex_halt, ex_ill;
    logic [15:0] ls_addr;
    logic [3:0]  dec_a_idx, dec_b_idx;

    function automatic logic [BANK_BITS-1:0] even_index(input logic [15:0] a);
        logic [MEM_ADDR_BITS-1:0] am;
        am = a[MEM_ADDR_BITS-1:0] + MEM_ADDR_BITS'(a[0]);
        return am[MEM_ADDR_BITS-1:1];
    endfunction

    function automatic logic [1:0] sub_cv(input logic [15:0] a, input logic [15:0] b);
        logic [15:0] d;
        d = a - b;
        return {a >= b, ((a ^ b) & (a ^ d)) >> 15 != 16'd0};
    endfunction

    function automatic logic [1:0] add_cv(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return {s[16], ((~(a ^ b)) & (a ^ s[15:0])) >> 15 != 16'd0};
    endfunction

    function automatic logic [1:0] nz(input logic [31:0] v);
        return {v[15], v == 32'd0};
    endfunction

    function automatic logic cond_true(input logic [3:0] c, input logic [3:0] f);
        logic n, z, cy, v, t;
        n  = f[3];
        z  = f[2];
        cy = f[1];
        v  = f[0];
        case (c)
            4'd0:    t = z;
            4'd1:    t = !z;
            4'd2:    t = cy;
            4'd3:    t = !cy;
            4'd4:    t = n;
            4'd5:    t = !n;
            4'd6:    t = v;
            4'd7:    t = !v;
            4'd8:    t = cy && !z;
            4'd9:    t = !cy || z;
            4'd10:   t = (n == v);
            4'd11:   t = (n != v);
            4'd12:   t = !z && (n == v);
            4'd13:   t = z || (n != v);
            default: t = 1'b0;
        endcase
        return t;
    endfunction

    sbie_ram #(.WIDTH(8), .DEPTH(BANK_DEPTH)) u_even_bank (
        .clk(clk), .wr_en(even_we), .wr_addr(even_wr_idx), .wr_data(even_wd),
        .rd_en(bank_rd_en), .rd_addr(even_rd_idx), .rd_data(even_q)
    );

    sbie_ram #(.WIDTH(8), .DEPTH(BANK_DEPTH)) u_odd_bank (
        .clk(clk), .wr_en(odd_we), .wr_addr(odd_wr_idx), .wr_data(odd_wd),
        .rd_en(bank_rd_en), .rd_addr(odd_rd_idx), .rd_data(odd_q)
    );

    sbie_ram #(.WIDTH(32), .DEPTH(16)) u_rf_a (
        .clk(clk), .wr_en(rf_we), .wr_addr(rf_wr_idx), .wr_data(rf_wr_data),
        .rd_en(rf_rd_en), .rd_addr(dec_a_idx), .rd_data(rfa_q)
    );

    sbie_ram #(.WIDTH(32), .DEPTH(16)) u_rf_b (
        .clk(clk), .wr_en(rf_we), .wr_addr(rf_wr_idx), .wr_data(rf_wr_data),
        .rd_en(rf_rd_en), .rd_addr(dec_b_idx), .rd_data(rfb_q)
    );

    assign out_free    = !out_valid_reg || out_ready;
    assign even_rd_idx = even_index(bank_rd_addr);
    assign odd_rd_idx  = bank_rd_addr[MEM_ADDR_BITS-1:1];
    assign byte_lo     = addr0_reg ? odd_q : even_q;
    assign byte_hi     = addr0_reg ? even_q : odd_q;

    assign even_wr_idx = even_index(mem_wr_addr);
    assign odd_wr_idx  = mem_wr_addr[MEM_ADDR_BITS-1:1];
    assign even_wd     = mem_wr_addr[0] ? mem_wr_data[15:8] : mem_wr_data[7:0];
    assign odd_wd      = mem_wr_addr[0] ? mem_wr_data[7:0] : mem_wr_data[15:8];
    assign even_we     = (mem_wr_kind == sbie_pkg::STORE_HALF)
                         || (mem_wr_kind == sbie_pkg::STORE_BYTE && !mem_wr_addr[0]);
    assign odd_we      = (mem_wr_kind == sbie_pkg::STORE_HALF)
                         || (mem_wr_kind == sbie_pkg::STORE_BYTE && mem_wr_addr[0]);

    assign opa = (a_idx_reg == sbie_pkg::PC_INDEX) ? {16'd0, pc_reg}
               : (valid_reg[a_idx_reg] ? rfa_q : 32'd0);
    assign opb = (b_idx_reg == sbie_pkg::PC_INDEX) ? {16'd0, pc_reg}
               : (valid_reg[b_idx_reg] ? rfb_q : 32'd0);

    // Operand indexes from the fetched halfword
    always_comb
    begin
        logic [15:0] ins;
        ins = {byte_hi, byte_lo};
        if (ins[15:10] == 6'b010001)
        begin
            dec_a_idx = {ins[7], ins[2:0]};
            dec_b_idx = ins[6:3];
        end
        else if (ins[15:13] == 3'b001)
        begin
            dec_a_idx = {1'b0, ins[10:8]};
            dec_b_idx = {1'b0, ins[5:3]};
        end
        else
        begin
            dec_a_idx = {1'b0, ins[2:0]};
            dec_b_idx = {1'b0, ins[5:3]};
        end
    end

    // Execute
    always_comb
    begin
        logic [7:0]  hi, lo;
        logic [31:0] r;
        logic [7:0]  amt;
        logic [15:0] r16;
        logic [15:0] npc;
        logic [31:0] off;
        hi  = ins_reg[15:8];
        lo  = ins_reg[7:0];
        r   = 32'd0;
        amt = opb[7:0];
        r16 = 16'd0;
        off = 32'd0;
        npc = pc_reg + 16'd2;
        res = '0;
        res.flag_bits = flags_reg;
        ld_mem  = 1'b0;
        ex_halt = 1'b0;
        ex_ill  = 1'b0;
        ls_addr = 16'd0;

        if (hi[7:5] == 3'd0)
        begin
            if (hi[4:0] != 5'd0)
            begin
                ex_ill = 1'b1;
            end
            else
            begin
                ex_halt = 1'b1;
            end
        end
        else if (hi[7:5] == 3'd1)
        begin
            case (hi[4:3])
                2'd0:
                begin
                    res.reg_write = 1'b1;
                    res.reg_index = {1'b0, hi[2:0]};
                    res.reg_value = {24'd0, lo};
                    res.flag_bits[3:2] = nz({24'd0, lo});
                end
                2'd1:
                begin
                    res.flag_bits[1:0] = sub_cv(opa[15:0], {8'd0, lo});
                    res.flag_bits[3:2] = nz(opa - {24'd0, lo});
                end
                default: ex_ill = 1'b1;
            endcase
        end
        else if (hi[7:2] == 6'd16)
        begin
            case (ins_reg[9:6])
                4'd0:
                begin
                    r = opa & opb;
                    res.reg_write = 1'b1;
                    res.reg_index = {1'b0, ins_reg[2:0]};
                    res.reg_value = r;
                    res.flag_bits[3:2] = nz(r);
                end
                4'd1:
                begin
                    r = opa ^ opb;
                    res.reg_write = 1'b1;
                    res.reg_index = {1'b0, ins_reg[2:0]};
                    res.reg_value = r;
                    res.flag_bits[3:2] = nz(r);
                end
                4'd2:
                begin
                    if (amt != 8'd0)
                    begin
                        if (amt < 8'd16)
                        begin
                            res.flag_bits[1] = opa[{1'b0, amt[3:0] - 4'd1}];
                            r = 32'($signed(opa) >>> amt[3:0]);
                        end
                        else
                        begin
                            res.flag_bits[1] = opa[15];
                            r = opa[15] ? 32'h0000FFFF : 32'd0;
                        end
                        res.reg_write = 1'b1;
                        res.reg_index = {1'b0, ins_reg[2:0]};
                        res.reg_value = r;
                        res.flag_bits[3:2] = nz(r);
                    end
                end
                4'd3: res.flag_bits[3:2] = nz(opa & opb);
                4'd4:
                begin
                    res.flag_bits[1:0] = sub_cv(16'd0, opb[15:0]);
                    r = {16'd0, 16'd0 - opb[15:0]};
                    res.reg_write = 1'b1;
                    res.reg_index = {1'b0, ins_reg[2:0]};
                    res.reg_value = r;
                    res.flag_bits[3:2] = nz(r);
                end
                4'd5:
                begin
                    res.flag_bits[1:0] = sub_cv(opa[15:0], opb[15:0]);
                    res.flag_bits[3:2] = nz(opa - opb);
                end
                default: ex_ill = 1'b1;
            endcase
        end
        else if (hi[7:2] == 6'd17)
        begin
            case (ins_reg[9:8])
                2'd0:
                begin
                    res.flag_bits[1:0] = add_cv(opa[15:0], opb[15:0]);
                    r16 = opa[15:0] + opb[15:0];
                    r = {{16{r16[15]}}, r16};
                    res.flag_bits[3:2] = nz(r);
                    res.reg_write = 1'b1;
                    res.reg_index = a_idx_reg;
                    if (a_idx_reg == sbie_pkg::PC_INDEX)
                    begin
                        npc = r16 + 16'd2;
                        res.reg_value = {16'd0, npc};
                    end
                    else
                    begin
                        res.reg_value = r;
                    end
                end
                2'd1:
                begin
                    res.flag_bits[1:0] = sub_cv(opa[15:0], opb[15:0]);
                    res.flag_bits[3:2] = nz(opa - opb);
                end
                2'd2:
                begin
                    res.flag_bits[3:2] = nz(opb);
                    res.reg_write = 1'b1;
                    res.reg_index = a_idx_reg;
                    if (a_idx_reg == sbie_pkg::PC_INDEX)
                    begin
                        npc = opb[15:0];
                        res.reg_value = {16'd0, npc};
                    end
                    else
                    begin
                        res.reg_value = opb;
                    end
                end
                default: ex_ill = 1'b1;
            endcase
        end
        else if (hi[7:5] == 3'd3)
        begin
            if (!ins_reg[12])
            begin
                ls_addr = (opb[15:0] & 16'hFFFC) + {9'd0, ins_reg[10:6], 2'd0};
            end
            else
            begin
                ls_addr = opb[15:0] + {11'd0, ins_reg[10:6]};
            end
            if (!ins_reg[11])
            begin
                res.store_addr = ls_addr;
                if (!ins_reg[12])
                begin
                    res.store_valid = sbie_pkg::STORE_HALF;
                    res.store_data  = opa[15:0];
                end
                else
                begin
                    res.store_valid = sbie_pkg::STORE_BYTE;
                    res.store_data  = {8'd0, opa[7:0]};
                end
            end
            else if (ls_addr == sbie_pkg::KEY_ADDR)
            begin
                res.reg_write = 1'b1;
                res.reg_index = {1'b0, ins_reg[2:0]};
                res.reg_value = {24'd0, key_reg};
                res.key_taken = 1'b1;
            end
            else
            begin
                ld_mem = 1'b1;
            end
        end
        else if (hi[7:4] == 4'd10)
        begin
            if (ins_reg[11])
            begin
                ex_ill = 1'b1;
            end
            else
            begin
                res.reg_write = 1'b1;
                res.reg_index = {1'b0, ins_reg[10:8]};
                res.reg_value = {16'd0, pc_reg & 16'hFFFC} + {22'd0, lo, 2'd0};
            end
        end
        else if (hi[7:4] == 4'd13)
        begin
            if (cond_true(ins_reg[11:8], flags_reg))
            begin
                off = {{23{lo[7]}}, lo, 1'b0};
                npc = pc_reg + off[15:0];
            end
        end
        else
        begin
            ex_ill = 1'b1;
        end

        if (ex_ill || ex_halt)
        begin
            res = '0;
            res.flag_bits = flags_reg;
            res.illegal   = ex_ill;
            res.halted    = ex_halt;
            npc = pc_reg;
        end
        res.pc_value = npc;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sbie_pkg::ST_IDLE:
            begin
                if (head.valid && head.item.func == sbie_pkg::FUNC_STEP && !stopped_reg)
                begin
                    state_next = sbie_pkg::ST_DECODE;
                end
            end
            sbie_pkg::ST_DECODE: state_next = sbie_pkg::ST_EXECUTE;
            sbie_pkg::ST_EXECUTE:
            begin
                if (ld_mem)
                begin
                    state_next = sbie_pkg::ST_LOAD;
                end
                else if (out_free)
                begin
                    state_next = sbie_pkg::ST_IDLE;
                end
            end
            sbie_pkg::ST_LOAD:
            begin
                if (out_free)
                begin
                    state_next = sbie_pkg::ST_IDLE;
                end
            end
            default: state_next = sbie_pkg::ST_IDLE;
        endcase
    end

    // Outputs and register updates
    always_comb
    begin
        pop            = 1'b0;
        commit         = 1'b0;
        bank_rd_en     = 1'b0;
        bank_rd_addr   = pc_reg;
        rf_rd_en       = 1'b0;
        mem_wr_kind    = sbie_pkg::STORE_NONE;
        mem_wr_addr    = res.store_addr;
        mem_wr_data    = res.store_data;
        rf_we          = 1'b0;
        rf_wr_idx      = res.reg_index;
        rf_wr_data     = res.reg_value;
        pc_next        = pc_reg;
        flags_next     = flags_reg;
        stopped_next   = stopped_reg;
        valid_next     = valid_reg;
        out_word_next  = out_word_reg;
        ins_next       = ins_reg;
        key_next       = key_reg;
        addr0_next     = addr0_reg;
        a_idx_next     = a_idx_reg;
        b_idx_next     = b_idx_reg;

        case (state_reg)
            sbie_pkg::ST_IDLE:
            begin
                if (head.valid)
                begin
                    if (head.item.func == sbie_pkg::FUNC_STEP && !stopped_reg)
                    begin
                        pop          = 1'b1;
                        bank_rd_en   = 1'b1;
                        bank_rd_addr = pc_reg;
                        addr0_next   = pc_reg[0];
                        key_next     = head.item.key_code;
                    end
                    else if (out_free)
                    begin
                        pop    = 1'b1;
                        commit = 1'b1;
                        out_word_next = '0;
                        out_word_next.pc_value  = pc_reg;
                        out_word_next.flag_bits = flags_reg;
                        if (head.item.func == sbie_pkg::FUNC_LOAD)
                        begin
                            mem_wr_kind = sbie_pkg::STORE_BYTE;
                            mem_wr_addr = head.item.load_addr;
                            mem_wr_data = {8'd0, head.item.load_data};
                        end
                    end
                end
            end
            sbie_pkg::ST_DECODE:
            begin
                rf_rd_en   = 1'b1;
                ins_next   = {byte_hi, byte_lo};
                a_idx_next = dec_a_idx;
                b_idx_next = dec_b_idx;
            end
            sbie_pkg::ST_EXECUTE:
            begin
                if (ld_mem)
                begin
                    bank_rd_en   = 1'b1;
                    bank_rd_addr = ls_addr;
                    addr0_next   = ls_addr[0];
                end
                else if (out_free)
                begin
                    commit        = 1'b1;
                    out_word_next = res;
                    pc_next       = res.pc_value;
                    flags_next    = res.flag_bits;
                    stopped_next  = res.halted || res.illegal;
                    mem_wr_kind   = res.store_valid;
                    if (res.reg_write && res.reg_index != sbie_pkg::PC_INDEX)
                    begin
                        rf_we = 1'b1;
                        valid_next[res.reg_index] = 1'b1;
                    end
                end
            end
            sbie_pkg::ST_LOAD:
            begin
                if (out_free)
                begin
                    commit     = 1'b1;
                    rf_we      = 1'b1;
                    rf_wr_idx  = {1'b0, ins_reg[2:0]};
                    rf_wr_data = ins_reg[12] ? {24'd0, byte_lo} : {16'd0, byte_hi, byte_lo};
                    valid_next[rf_wr_idx] = 1'b1;
                    pc_next    = pc_reg + 16'd2;
                    out_word_next = '0;
                    out_word_next.pc_value  = pc_reg + 16'd2;
                    out_word_next.flag_bits = flags_reg;
                    out_word_next.reg_write = 1'b1;
                    out_word_next.reg_index = rf_wr_idx;
                    out_word_next.reg_value = rf_wr_data;
                end
            end
            default: ;
        endcase

        if (commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sbie_pkg::ST_IDLE;
            pc_reg        <= 16'd0;
            flags_reg     <= 4'd0;
            stopped_reg   <= 1'b0;
            valid_reg     <= 16'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pc_reg        <= pc_next;
            flags_reg     <= flags_next;
            stopped_reg   <= stopped_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_word_reg <= out_word_next;
        ins_reg      <= ins_next;
        key_reg      <= key_next;
        addr0_reg    <= addr0_next;
        a_idx_reg    <= a_idx_next;
        b_idx_reg    <= b_idx_next;
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;
endmodule
